/* design/ip_address_alu_core_macros.svh */
// Assertion helpers for the address ALU core.
// Each macro expects i_clk and i_rst_n in the enclosing scope.
`ifndef IP_ADDRESS_ALU_CORE_MACROS_SVH
`define IP_ADDRESS_ALU_CORE_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define IPALU_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset
`define IPALU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/ipalu_pkg.sv */
package ipalu_pkg;

    localparam int ADDR_W   = 128;
    localparam int HALF_W   = 64;
    localparam int V4_W     = 32;
    localparam int V4_SH_W  = $clog2(V4_W);
    localparam int OP_W     = 3;
    localparam int CNT_W    = $clog2(ADDR_W);
    localparam int FINE_W   = 4;

    typedef enum logic [OP_W-1:0] {
        OP_NEG   = 3'd0,
        OP_NOT   = 3'd1,
        OP_ADD_S = 3'd2,
        OP_SUB_S = 3'd3,
        OP_ADD_A = 3'd4,
        OP_SUB_A = 3'd5,
        OP_SHR   = 3'd6,
        OP_SHL   = 3'd7
    } t_op;

    // decoded operands, adder inputs already prepared
    typedef struct packed {
        t_op               op;
        logic              v4;
        logic              neg;
        logic [ADDR_W-1:0] x;
        logic [ADDR_W-1:0] y;
        logic              cin;
        logic [CNT_W-1:0]  shamt;
        logic              cnt_ok;
    } t_s1;

    // low half summed, coarse shift done
    typedef struct packed {
        t_op               op;
        logic              v4;
        logic              neg;
        logic [HALF_W-1:0] x_hi;
        logic [HALF_W-1:0] y_hi;
        logic              c_lo;
        logic [HALF_W-1:0] sum_lo;
        logic [ADDR_W-1:0] shc;
        logic [FINE_W-1:0] fine;
        logic              cnt_ok;
    } t_s2;

    // full sum and full shift ready for resolution
    typedef struct packed {
        t_op               op;
        logic              v4;
        logic              neg;
        logic              carry;
        logic [ADDR_W-1:0] sum;
        logic [ADDR_W-1:0] shf;
        logic              cnt_ok;
    } t_s3;

endpackage

/* design/ipalu_if.sv */
// Request channel: one address operation per transaction
interface ipalu_req_if;
    import ipalu_pkg::*;

    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   operation;
    logic              ipv4_mode;
    logic [HALF_W-1:0] address_hi;
    logic [HALF_W-1:0] address_lo;
    logic [HALF_W-1:0] operand_hi;
    logic [HALF_W-1:0] operand_lo;

    modport source (
        output valid, operation, ipv4_mode, address_hi, address_lo, operand_hi, operand_lo,
        input  ready
    );
    modport sink (
        input  valid, operation, ipv4_mode, address_hi, address_lo, operand_hi, operand_lo,
        output ready
    );
endinterface

// Response channel: result and its valid flag
interface ipalu_rsp_if;
    import ipalu_pkg::*;

    logic              valid;
    logic              ready;
    logic [HALF_W-1:0] result_hi;
    logic [HALF_W-1:0] result_lo;
    logic              valid_res;

    modport source (
        output valid, result_hi, result_lo, valid_res,
        input  ready
    );
    modport sink (
        input  valid, result_hi, result_lo, valid_res,
        output ready
    );
endinterface

/* design/ipalu_decode.sv */
// Stage 1: operand selection, adder input prep, shift count check
module ipalu_decode (
    input  logic            i_clk,
    input  logic            i_rst_n,
    ipalu_req_if.sink       i_req,
    input  logic            i_ready,
    output logic            o_vld,
    output ipalu_pkg::t_s1  o_s1
);
    import ipalu_pkg::*;

    logic              r_vld;
    t_s1               r_s1;
    t_s1               n_s1;
    logic [ADDR_W-1:0] a;
    logic [ADDR_W-1:0] b;
    logic [ADDR_W-1:0] s;
    logic              v4;

    // pipeline advance
    assign i_req.ready = !r_vld || i_ready;

    // operand build
    always_comb begin
        v4 = i_req.ipv4_mode;
        a  = v4 ? {{(ADDR_W-V4_W){1'b0}}, i_req.address_lo[V4_W-1:0]}
                : {i_req.address_hi, i_req.address_lo};
        b  = v4 ? {{(ADDR_W-V4_W){1'b0}}, i_req.operand_lo[V4_W-1:0]}
                : {i_req.operand_hi, i_req.operand_lo};
        s  = {{(ADDR_W-HALF_W){i_req.operand_lo[HALF_W-1]}}, i_req.operand_lo};

        n_s1.op     = t_op'(i_req.operation);
        n_s1.v4     = v4;
        n_s1.neg    = i_req.operand_lo[HALF_W-1];
        n_s1.x      = a;
        n_s1.y      = '0;
        n_s1.cin    = 1'b0;
        n_s1.shamt  = i_req.operand_lo[CNT_W-1:0];
        // count must be below 128, or below 32 in IPv4 mode
        n_s1.cnt_ok = (i_req.operand_lo[HALF_W-1:CNT_W] == '0) &&
                      (!v4 || (i_req.operand_lo[CNT_W-1:V4_SH_W] == '0));

        case (n_s1.op)
            OP_NEG: begin
                n_s1.x   = ~a;
                n_s1.cin = 1'b1;
            end
            OP_NOT: begin
                n_s1.x = ~a;
            end
            OP_ADD_S: begin
                n_s1.y = s;
            end
            OP_SUB_S: begin
                n_s1.y   = ~s;
                n_s1.cin = 1'b1;
            end
            OP_ADD_A: begin
                n_s1.y = b;
            end
            OP_SUB_A: begin
                n_s1.y   = ~b;
                n_s1.cin = 1'b1;
            end
            default: begin
                n_s1.y = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_req.ready) begin
            r_vld <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.ready && i_req.valid) begin
            r_s1 <= n_s1;
        end
    end

    assign o_vld = r_vld;
    assign o_s1  = r_s1;

endmodule

/* design/ipalu_exec.sv */
// Stages 2 and 3: 128-bit add split in two 64-bit halves, two-step barrel shift
module ipalu_exec (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_vld,
    input  ipalu_pkg::t_s1  i_s1,
    output logic            o_ready,
    output logic            o_vld,
    output ipalu_pkg::t_s3  o_s3,
    input  logic            i_ready
);
    import ipalu_pkg::*;

    logic              r_vld2;
    logic              r_vld3;
    t_s2               r_s2;
    t_s2               n_s2;
    t_s3               r_s3;
    t_s3               n_s3;
    logic              rdy2;
    logic              rdy3;
    logic [HALF_W:0]   lo_sum;
    logic [HALF_W:0]   hi_sum;
    logic [CNT_W-1:0]  coarse;

    assign rdy3    = !r_vld3 || i_ready;
    assign rdy2    = !r_vld2 || rdy3;
    assign o_ready = rdy2;

    // stage 2: low half add, shift by multiples of 16
    always_comb begin
        lo_sum = {1'b0, i_s1.x[HALF_W-1:0]} + {1'b0, i_s1.y[HALF_W-1:0]}
               + {{HALF_W{1'b0}}, i_s1.cin};
        coarse = {i_s1.shamt[CNT_W-1:FINE_W], {FINE_W{1'b0}}};

        n_s2.op     = i_s1.op;
        n_s2.v4     = i_s1.v4;
        n_s2.neg    = i_s1.neg;
        n_s2.x_hi   = i_s1.x[ADDR_W-1:HALF_W];
        n_s2.y_hi   = i_s1.y[ADDR_W-1:HALF_W];
        n_s2.c_lo   = lo_sum[HALF_W];
        n_s2.sum_lo = lo_sum[HALF_W-1:0];
        n_s2.shc    = (i_s1.op == OP_SHL) ? (i_s1.x << coarse) : (i_s1.x >> coarse);
        n_s2.fine   = i_s1.shamt[FINE_W-1:0];
        n_s2.cnt_ok = i_s1.cnt_ok;
    end

    // stage 3: high half add with carry, residual shift
    always_comb begin
        hi_sum = {1'b0, r_s2.x_hi} + {1'b0, r_s2.y_hi} + {{HALF_W{1'b0}}, r_s2.c_lo};

        n_s3.op     = r_s2.op;
        n_s3.v4     = r_s2.v4;
        n_s3.neg    = r_s2.neg;
        n_s3.carry  = hi_sum[HALF_W];
        n_s3.sum    = {hi_sum[HALF_W-1:0], r_s2.sum_lo};
        n_s3.shf    = (r_s2.op == OP_SHL) ? (r_s2.shc << r_s2.fine) : (r_s2.shc >> r_s2.fine);
        n_s3.cnt_ok = r_s2.cnt_ok;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld2 <= 1'b0;
            r_vld3 <= 1'b0;
        end else begin
            if (rdy2) begin
                r_vld2 <= i_vld;
            end
            if (rdy3) begin
                r_vld3 <= r_vld2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy2 && i_vld) begin
            r_s2 <= n_s2;
        end
        if (rdy3 && r_vld2) begin
            r_s3 <= n_s3;
        end
    end

    assign o_vld = r_vld3;
    assign o_s3  = r_s3;

endmodule

/* design/ipalu_finish.sv */
// Stage 4: range check, IPv4 masking, zero on invalid, output register
module ipalu_finish (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_vld,
    input  ipalu_pkg::t_s3  i_s3,
    output logic            o_ready,
    ipalu_rsp_if.source     o_rsp
);
    import ipalu_pkg::*;

    logic              r_vld;
    logic [ADDR_W-1:0] r_res;
    logic              r_ok;
    logic [ADDR_W-1:0] n_res;
    logic              n_ok;
    logic [ADDR_W-1:0] res;
    logic              ok;
    logic              keep_v4;
    logic              upper_bad;

    assign o_ready = !r_vld || o_rsp.ready;

    always_comb begin
        res = i_s3.sum;
        ok  = 1'b1;
        case (i_s3.op)
            OP_NEG: begin
                ok = 1'b1;
            end
            OP_NOT: begin
                ok = !i_s3.v4;
            end
            OP_ADD_S: begin
                ok = i_s3.neg ? i_s3.carry : !i_s3.carry;
            end
            OP_SUB_S: begin
                // carry set means no borrow
                ok = i_s3.neg ? !i_s3.carry : i_s3.carry;
            end
            OP_ADD_A: begin
                ok = !i_s3.carry;
            end
            OP_SUB_A: begin
                ok = i_s3.carry;
            end
            OP_SHR, OP_SHL: begin
                res = i_s3.shf;
                ok  = i_s3.cnt_ok;
            end
            default: begin
                ok = 1'b0;
            end
        endcase

        // negate and left shift wrap to 32 bits in IPv4; others must fit
        keep_v4   = (i_s3.op == OP_NEG) || (i_s3.op == OP_SHL);
        upper_bad = i_s3.v4 && (res[ADDR_W-1:V4_W] != '0) && !keep_v4;
        n_ok      = ok && !upper_bad;
        if (!n_ok) begin
            n_res = '0;
        end else if (i_s3.v4) begin
            n_res = {{(ADDR_W-V4_W){1'b0}}, res[V4_W-1:0]};
        end else begin
            n_res = res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_vld) begin
            r_res <= n_res;
            r_ok  <= n_ok;
        end
    end

    assign o_rsp.valid     = r_vld;
    assign o_rsp.result_hi = r_res[ADDR_W-1:HALF_W];
    assign o_rsp.result_lo = r_res[HALF_W-1:0];
    assign o_rsp.valid_res = r_ok;

endmodule

/* design/ip_address_alu_core.sv */
// IPv6/IPv4 address ALU. Accepts one transaction per clock while the input
// is not stalled and returns one result per transaction, in order, after it
// passes the register stages. The four register stages are: operand decode,
// low 64-bit add plus coarse shift, high 64-bit add plus fine shift, and
// range check into the output register. Ready is derived stage by stage, so
// empty stages keep filling while a result waits at the output; the input
// stalls only when all four stages hold transactions. Invalid results
// (overflow, underflow, bad shift count, IPv4 complement) come back as zero
// with valid_res low.
`include "ip_address_alu_core_macros.svh"

module ip_address_alu_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ipalu_req_if.sink     i_req,
    ipalu_rsp_if.source   o_rsp
);
    import ipalu_pkg::*;

    logic vld1;
    t_s1  s1;
    logic rdy2;
    logic vld3;
    t_s3  s3;
    logic rdy4;
    logic rsp_bad;
    logic rsp_zero;
    logic out_held;
    logic req_acc;

    ipalu_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_ready (rdy2),
        .o_vld   (vld1),
        .o_s1    (s1)
    );

    ipalu_exec u_exec (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (vld1),
        .i_s1    (s1),
        .o_ready (rdy2),
        .o_vld   (vld3),
        .o_s3    (s3),
        .i_ready (rdy4)
    );

    ipalu_finish u_finish (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (vld3),
        .i_s3    (s3),
        .o_ready (rdy4),
        .o_rsp   (o_rsp)
    );

    // check terms
    assign rsp_bad  = o_rsp.valid && !o_rsp.valid_res;
    assign rsp_zero = (o_rsp.result_hi == '0) && (o_rsp.result_lo == '0);
    assign out_held = o_rsp.valid && !o_rsp.ready && vld1 && vld3;
    assign req_acc  = i_req.valid && i_req.ready;

    // checks
    `IPALU_ASSERT_NOW(a_invalid_is_zero, rsp_bad, rsp_zero, "invalid result not zeroed")
    `IPALU_ASSERT_NOW(a_stall_only_when_full, !i_req.ready, out_held, "stall with free stage")
    `IPALU_ASSERT_NEXT(a_accept_loads_stage1, req_acc, vld1, "accepted transaction lost")

endmodule
